// ----- hw/rtl/particle_pool_integrator_unit_assert.svh -----
// Assertion macros shared by the particle pool integrator RTL.
`ifndef PARTICLE_POOL_INTEGRATOR_UNIT_ASSERT_SVH
`define PARTICLE_POOL_INTEGRATOR_UNIT_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while in reset.
`define PPI_ASSERT_IMP(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// Next-cycle implication, clocked on clk, off while in reset.
`define PPI_ASSERT_NXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/ppi_pkg.sv -----
// Package: widths, register indexes and saturating add for the particle pool integrator.
package ppi_pkg;

    localparam int POOL_SIZE_DEF = 64;
    localparam int DW            = 32;
    localparam int MASS_W        = 31;
    localparam int SLOT_W        = 6;
    localparam int CFG_IDX_W     = 8;
    localparam int IN_DATA_W     = 224;
    localparam int OUT_DATA_W    = 104;
    localparam int DIV_STEPS     = 24;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_Y = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIND_X    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIND_Y    = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIND_Z    = 8'd3;

    // register reset values, Q16.16
    localparam logic signed [DW-1:0] GRAVITY_Y_RST = -32'sd655;
    localparam logic signed [DW-1:0] WIND_X_RST    = 32'sd66;

    localparam logic ACT_SPAWN = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // signed add clamped to the 32-bit range
    function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
                                                     input logic signed [DW-1:0] b);
        logic signed [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1])
            sat_add = s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        else
            sat_add = s[DW-1:0];
    endfunction

endpackage

// ----- hw/rtl/ppi_div.sv -----
// Radix-4 restoring divider: saturated (force * 65536) / mass, truncated toward zero.
module ppi_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic signed [ppi_pkg::DW-1:0] dividend,
    input  logic [ppi_pkg::MASS_W-1:0]    divisor,
    output logic                          done,
    output logic signed [ppi_pkg::DW-1:0] quotient
);
    import ppi_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [4:0]            cnt_reg, cnt_next;
    logic                  neg_reg, neg_next;
    logic [47:0]           dvd_reg, dvd_next;
    logic [DW-1:0]         rem_reg, rem_next;
    logic [MASS_W-1:0]     m_reg, m_next;
    logic signed [DW-1:0]  q_reg, q_next;
    logic [DW-1:0]         mag;
    logic [DW-1:0]         t;
    logic [47:0]           d;
    logic [47:0]           qf;

    assign mag = dividend[DW-1] ? (~dividend + 32'd1) : dividend;

    // two quotient bits per cycle, then sign and clamp
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        m_next    = m_reg;
        q_next    = q_reg;
        t         = rem_reg;
        d         = dvd_reg;
        qf        = '0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            neg_next  = dividend[DW-1];
            dvd_next  = {mag, 16'd0};
            rem_next  = '0;
            m_next    = (divisor == '0) ? MASS_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            for (int k = 0; k < 2; k++)
            begin
                t = {t[DW-2:0], d[47]};
                d = {d[46:0], 1'b0};
                if (t >= {1'b0, m_reg})
                begin
                    t    = t - {1'b0, m_reg};
                    d[0] = 1'b1;
                end
            end
            rem_next = t;
            dvd_next = d;
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
                qf        = d;
                if (neg_reg)
                begin
                    if ((|qf[47:32]) || (qf[31] && (|qf[30:0])))
                        q_next = {1'b1, {(DW-1){1'b0}}};
                    else
                        q_next = ~qf[31:0] + 32'd1;
                end
                else
                begin
                    if (|qf[47:31])
                        q_next = {1'b0, {(DW-1){1'b1}}};
                    else
                        q_next = qf[31:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        m_reg   <= m_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ----- hw/rtl/particle_pool_integrator_unit.sv -----
// Top level: particle pool with next-fit spawn and Euler tick on one shared saturating adder.
//
// channel | dir | handshake          | payload
// s_      | in  | s_tvalid/s_tready  | s_tdata, s_tuser (action)
// m_      | out | m_tvalid/m_tready  | m_tdata, m_tuser, m_tlast
// cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Spawn: search the slots from the cursor (up to POOL_SIZE tried), write the three components, then one result.
// Tick: scan every slot, then per live slot and per component x, y, z: read, force add (two for y),
// divider start, divider wait, three adds; plus a slot step per slot visited and one result per
// live slot.
// s_tready is low while an item is in work; a stalled m_tready holds the sequencer.
// Reset clears live flags and cursor and loads the configuration registers; the stores need no clearing pass.
`include "particle_pool_integrator_unit_assert.svh"
module particle_pool_integrator_unit #(
    parameter int POOL_SIZE = ppi_pkg::POOL_SIZE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pos_x, pos_y, pos_z, force_x, force_y, force_z, mass(31), pad(1)
    input  logic [ppi_pkg::IN_DATA_W-1:0]     s_tdata,
    // action
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // slot(6), out_pos_x, out_pos_y, out_pos_z, pad(2)
    output logic [ppi_pkg::OUT_DATA_W-1:0]    m_tdata,
    // valid_res, removed
    output logic [1:0]                        m_tuser,
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ppi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppi_pkg::DW-1:0]            cfg_data
);
    import ppi_pkg::*;

    localparam int IW        = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int MEM_DEPTH = POOL_SIZE * 3;
    localparam int AW        = $clog2(MEM_DEPTH);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SRCH = 4'd1;
    localparam logic [3:0] ST_SPWR = 4'd2;
    localparam logic [3:0] ST_SCAN = 4'd3;
    localparam logic [3:0] ST_NEXT = 4'd4;
    localparam logic [3:0] ST_RD   = 4'd5;
    localparam logic [3:0] ST_F1   = 4'd6;
    localparam logic [3:0] ST_F2   = 4'd7;
    localparam logic [3:0] ST_DST  = 4'd8;
    localparam logic [3:0] ST_DWT  = 4'd9;
    localparam logic [3:0] ST_AADD = 4'd10;
    localparam logic [3:0] ST_SADD = 4'd11;
    localparam logic [3:0] ST_PADD = 4'd12;
    localparam logic [3:0] ST_OUT  = 4'd13;

    localparam logic [IW-1:0] IDX_TOP = IW'(POOL_SIZE - 1);

    logic [3:0]             state_reg, state_next;
    logic [POOL_SIZE-1:0]   live_reg, live_next;
    logic [IW-1:0]          cursor_reg, cursor_next;
    logic [IW-1:0]          idx_reg, idx_next;
    logic [IW-1:0]          cnt_reg, cnt_next;
    logic [IW-1:0]          last_idx_reg, last_idx_next;
    logic                   any_reg, any_next;
    logic [1:0]             comp_reg, comp_next;
    logic signed [DW-1:0]   grav_reg, grav_next;
    logic signed [DW-1:0]   wx_reg, wx_next;
    logic signed [DW-1:0]   wy_reg, wy_next;
    logic signed [DW-1:0]   wz_reg, wz_next;
    logic [IN_DATA_W-1:0]   in_reg;
    logic signed [DW-1:0]   f_reg, f_next;
    logic signed [DW-1:0]   a_reg, a_next;
    logic signed [DW-1:0]   s_reg, s_next;
    logic signed [DW-1:0]   px_reg, px_next;
    logic signed [DW-1:0]   py_reg, py_next;
    logic signed [DW-1:0]   pz_reg, pz_next;
    logic [SLOT_W-1:0]      slot_reg, slot_next;
    logic                   vres_reg, vres_next;
    logic                   rem_reg, rem_next;
    logic                   last_reg, last_next;

    logic signed [DW-1:0]   pos_mem   [0:MEM_DEPTH-1];
    logic signed [DW-1:0]   force_mem [0:MEM_DEPTH-1];
    logic signed [DW-1:0]   acc_mem   [0:MEM_DEPTH-1];
    logic signed [DW-1:0]   spd_mem   [0:MEM_DEPTH-1];
    logic [MASS_W-1:0]      mass_mem  [0:POOL_SIZE-1];
    logic signed [DW-1:0]   p_rd, f_rd, a_rd, s_rd;
    logic [MASS_W-1:0]      m_rd;

    logic [AW-1:0]          addr;
    logic                   we;
    logic signed [DW-1:0]   pos_w, force_w, acc_w, spd_w;
    logic signed [DW-1:0]   in_pos, in_force;
    logic signed [DW-1:0]   add_a, add_b, add_y;
    logic                   in_acc;
    logic                   div_start, div_done;
    logic signed [DW-1:0]   div_q;

    assign in_acc    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign addr      = AW'({idx_reg, 1'b0}) + AW'(idx_reg) + AW'(comp_reg);

    // spawn payload per component
    always_comb
    begin
        case (comp_reg)
            2'd0:
            begin
                in_pos   = in_reg[31:0];
                in_force = in_reg[127:96];
            end
            2'd1:
            begin
                in_pos   = in_reg[63:32];
                in_force = in_reg[159:128];
            end
            default:
            begin
                in_pos   = in_reg[95:64];
                in_force = in_reg[191:160];
            end
        endcase
    end

    // shared saturating adder operand select
    always_comb
    begin
        case (state_reg)
            ST_F1:
            begin
                add_a = f_rd;
                add_b = (comp_reg == 2'd0) ? wx_reg : (comp_reg == 2'd1) ? grav_reg : wz_reg;
            end
            ST_F2:
            begin
                add_a = f_reg;
                add_b = wy_reg;
            end
            ST_AADD:
            begin
                add_a = a_rd;
                add_b = div_q;
            end
            ST_SADD:
            begin
                add_a = s_rd;
                add_b = a_reg;
            end
            ST_PADD:
            begin
                add_a = p_rd;
                add_b = s_reg;
            end
            default:
            begin
                add_a = '0;
                add_b = '0;
            end
        endcase
    end
    assign add_y = sat_add(add_a, add_b);

    // store write data
    assign we      = (state_reg == ST_SPWR) || (state_reg == ST_PADD);
    assign pos_w   = (state_reg == ST_SPWR) ? in_pos : add_y;
    assign force_w = (state_reg == ST_SPWR) ? in_force : f_reg;
    assign acc_w   = (state_reg == ST_SPWR) ? '0 : a_reg;
    assign spd_w   = (state_reg == ST_SPWR) ? '0 : s_reg;

    // particle stores, registered reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            pos_mem[addr]   <= pos_w;
            force_mem[addr] <= force_w;
            acc_mem[addr]   <= acc_w;
            spd_mem[addr]   <= spd_w;
        end
        p_rd <= pos_mem[addr];
        f_rd <= force_mem[addr];
        a_rd <= acc_mem[addr];
        s_rd <= spd_mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SPWR)
            mass_mem[idx_reg] <= in_reg[222:192];
        m_rd <= mass_mem[idx_reg];
    end

    assign div_start = (state_reg == ST_DST);

    ppi_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (f_reg),
        .divisor  (m_rd),
        .done     (div_done),
        .quotient (div_q)
    );

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        live_next     = live_reg;
        cursor_next   = cursor_reg;
        idx_next      = idx_reg;
        cnt_next      = cnt_reg;
        last_idx_next = last_idx_reg;
        any_next      = any_reg;
        comp_next     = comp_reg;
        grav_next     = grav_reg;
        wx_next       = wx_reg;
        wy_next       = wy_reg;
        wz_next       = wz_reg;
        f_next        = f_reg;
        a_next        = a_reg;
        s_next        = s_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        pz_next       = pz_reg;
        slot_next     = slot_reg;
        vres_next     = vres_reg;
        rem_next      = rem_reg;
        last_next     = last_reg;

        // register writes
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_GRAVITY_Y: grav_next = cfg_data;
                REG_WIND_X:    wx_next   = cfg_data;
                REG_WIND_Y:    wy_next   = cfg_data;
                REG_WIND_Z:    wz_next   = cfg_data;
                default:       ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    cnt_next = '0;
                    idx_next = '0;
                    any_next = 1'b0;
                    px_next  = '0;
                    py_next  = '0;
                    pz_next  = '0;
                    slot_next = '0;
                    vres_next = 1'b0;
                    rem_next  = 1'b0;
                    last_next = 1'b1;
                    state_next = (s_tuser[0] == ACT_TICK) ? ST_SCAN : ST_SRCH;
                end
            end
            ST_SRCH:
            begin
                if (!live_reg[cursor_reg])
                begin
                    idx_next   = cursor_reg;
                    comp_next  = 2'd0;
                    state_next = ST_SPWR;
                end
                else
                begin
                    cursor_next = (cursor_reg == IDX_TOP) ? '0 : cursor_reg + IW'(1);
                    cnt_next    = cnt_reg + IW'(1);
                    if (cnt_reg == IDX_TOP)
                        state_next = ST_OUT;
                end
            end
            ST_SPWR:
            begin
                comp_next = comp_reg + 2'd1;
                if (comp_reg == 2'd2)
                begin
                    live_next[idx_reg] = 1'b1;
                    slot_next  = SLOT_W'(idx_reg);
                    vres_next  = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_SCAN:
            begin
                if (live_reg[idx_reg])
                begin
                    last_idx_next = idx_reg;
                    any_next      = 1'b1;
                end
                idx_next = idx_reg + IW'(1);
                if (idx_reg == IDX_TOP)
                begin
                    idx_next   = '0;
                    state_next = (any_reg || live_reg[idx_reg]) ? ST_NEXT : ST_OUT;
                end
            end
            ST_NEXT:
            begin
                if (live_reg[idx_reg])
                begin
                    comp_next  = 2'd0;
                    state_next = ST_RD;
                end
                else
                    idx_next = idx_reg + IW'(1);
            end
            ST_RD:
                state_next = ST_F1;
            ST_F1:
            begin
                f_next     = add_y;
                state_next = (comp_reg == 2'd1) ? ST_F2 : ST_DST;
            end
            ST_F2:
            begin
                f_next     = add_y;
                state_next = ST_DST;
            end
            ST_DST:
                state_next = ST_DWT;
            ST_DWT:
            begin
                if (div_done)
                    state_next = ST_AADD;
            end
            ST_AADD:
            begin
                a_next     = add_y;
                state_next = ST_SADD;
            end
            ST_SADD:
            begin
                s_next     = add_y;
                state_next = ST_PADD;
            end
            ST_PADD:
            begin
                case (comp_reg)
                    2'd0:    px_next = add_y;
                    2'd1:    py_next = add_y;
                    default: pz_next = add_y;
                endcase
                comp_next  = comp_reg + 2'd1;
                state_next = ST_RD;
                if (comp_reg == 2'd2)
                begin
                    rem_next   = py_reg[DW-1];
                    if (py_reg[DW-1])
                        live_next[idx_reg] = 1'b0;
                    slot_next  = SLOT_W'(idx_reg);
                    vres_next  = 1'b1;
                    last_next  = (idx_reg == last_idx_reg);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (m_tready)
                begin
                    if (last_reg)
                        state_next = ST_IDLE;
                    else
                    begin
                        idx_next   = idx_reg + IW'(1);
                        state_next = ST_NEXT;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            live_reg   <= '0;
            cursor_reg <= '0;
            grav_reg   <= GRAVITY_Y_RST;
            wx_reg     <= WIND_X_RST;
            wy_reg     <= '0;
            wz_reg     <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            live_reg   <= live_next;
            cursor_reg <= cursor_next;
            grav_reg   <= grav_next;
            wx_reg     <= wx_next;
            wy_reg     <= wy_next;
            wz_reg     <= wz_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            in_reg <= s_tdata;
        idx_reg      <= idx_next;
        cnt_reg      <= cnt_next;
        last_idx_reg <= last_idx_next;
        any_reg      <= any_next;
        comp_reg     <= comp_next;
        f_reg        <= f_next;
        a_reg        <= a_next;
        s_reg        <= s_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        pz_reg       <= pz_next;
        slot_reg     <= slot_next;
        vres_reg     <= vres_next;
        rem_reg      <= rem_next;
        last_reg     <= last_next;
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {2'b00, pz_reg, py_reg, px_reg, slot_reg};
    assign m_tuser  = {rem_reg, vres_reg};
    assign m_tlast  = last_reg;

    `PPI_ASSERT_IMP(a_div_done_in_wait, div_done, state_reg == ST_DWT)
    `PPI_ASSERT_IMP(a_out_blocks_in, m_tvalid, !s_tready)
    `PPI_ASSERT_IMP(a_removed_is_valid, m_tvalid && m_tuser[1], m_tuser[0])
    `PPI_ASSERT_NXT(a_spawn_to_search, in_acc && (s_tuser[0] == ACT_SPAWN), state_reg == ST_SRCH)
    `PPI_ASSERT_NXT(a_tick_to_scan, in_acc && (s_tuser[0] == ACT_TICK), state_reg == ST_SCAN)

endmodule

// ----- bench/tb_particle_pool_integrator_unit.sv -----
// Testbench for the particle pool integrator: random spawn/tick stream against an in-bench pool model.
module tb_particle_pool_integrator_unit;
    import ppi_pkg::*;

    localparam int NSLOT     = POOL_SIZE_DEF;
    localparam int CYCLE_CAP = 3000000;

    // index outside the register file, must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_IDX = 8'd200;

    typedef struct packed {
        logic [SLOT_W-1:0]    slot;
        logic                 ok;
        logic signed [DW-1:0] px;
        logic signed [DW-1:0] py;
        logic signed [DW-1:0] pz;
        logic                 removed;
        logic                 last;
    } pool_result_t;

    typedef struct packed {
        logic                     action;
        logic [IN_DATA_W-1:0]     payload;
    } pool_request_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata = '0;
    logic [0:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0] m_tuser;
    logic m_tlast;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DW-1:0] cfg_data = '0;

    particle_pool_integrator_unit u_top (.*);

    always #5 clk = ~clk;

    // pool shadow state
    logic signed [DW-1:0] g_y, w_x, w_y, w_z;
    bit                   alive [NSLOT];
    int unsigned          cursor;
    logic signed [DW-1:0] pos [NSLOT][3];
    logic signed [DW-1:0] frc [NSLOT][3];
    logic signed [DW-1:0] acc [NSLOT][3];
    logic signed [DW-1:0] spd [NSLOT][3];
    logic [MASS_W-1:0]    mass [NSLOT];

    pool_request_t pending_requests[$];
    pool_result_t  expected_results[$];
    int  mismatches = 0;
    bit  quiet_phase = 1'b0;
    longint cycles = 0;

    function automatic logic signed [DW-1:0] clamp_add(logic signed [DW-1:0] a,
                                                       logic signed [DW-1:0] b);
        longint s;
        s = longint'(a) + longint'(b);
        if (s > 64'sd2147483647) return 32'h7fffffff;
        if (s < -64'sd2147483648) return 32'h80000000;
        return s[31:0];
    endfunction

    function automatic logic signed [DW-1:0] force_over_mass(logic signed [DW-1:0] f,
                                                             logic [MASS_W-1:0] m);
        longint d, q;
        d = (m == 0) ? 1 : longint'({1'b0, m});
        q = (longint'(f) * 65536) / d;
        if (q > 64'sd2147483647) return 32'h7fffffff;
        if (q < -64'sd2147483648) return 32'h80000000;
        return q[31:0];
    endfunction

    function automatic pool_result_t blank_result();
        pool_result_t r;
        r = '0;
        r.last = 1'b1;
        return r;
    endfunction

    // compute the results of one accepted request
    task automatic predict_pool(pool_request_t rq);
        int found, last_live;
        pool_result_t r;
        found = -1;
        last_live = -1;
        if (rq.action == ACT_SPAWN) begin
            for (int i = 0; i < NSLOT; i++) begin
                if (!alive[cursor]) begin
                    found = cursor;
                    break;
                end
                cursor = (cursor + 1 >= NSLOT) ? 0 : cursor + 1;
            end
            r = blank_result();
            if (found >= 0) begin
                for (int c = 0; c < 3; c++) begin
                    pos[found][c] = rq.payload[c*32 +: 32];
                    frc[found][c] = rq.payload[96 + c*32 +: 32];
                    acc[found][c] = '0;
                    spd[found][c] = '0;
                end
                mass[found] = rq.payload[192 +: MASS_W];
                alive[found] = 1'b1;
                r.slot = SLOT_W'(found);
                r.ok = 1'b1;
            end
            expected_results.push_back(r);
            return;
        end
        for (int i = 0; i < NSLOT; i++)
            if (alive[i]) last_live = i;
        if (last_live < 0) begin
            expected_results.push_back(blank_result());
            return;
        end
        for (int i = 0; i < NSLOT; i++) begin
            if (!alive[i]) continue;
            frc[i][1] = clamp_add(frc[i][1], g_y);
            frc[i][0] = clamp_add(frc[i][0], w_x);
            frc[i][1] = clamp_add(frc[i][1], w_y);
            frc[i][2] = clamp_add(frc[i][2], w_z);
            for (int c = 0; c < 3; c++) begin
                acc[i][c] = clamp_add(acc[i][c], force_over_mass(frc[i][c], mass[i]));
                spd[i][c] = clamp_add(spd[i][c], acc[i][c]);
                pos[i][c] = clamp_add(pos[i][c], spd[i][c]);
            end
            r = '0;
            r.slot = SLOT_W'(i);
            r.ok = 1'b1;
            r.px = pos[i][0];
            r.py = pos[i][1];
            r.pz = pos[i][2];
            r.removed = pos[i][1] < 0;
            r.last = (i == last_live);
            if (r.removed) alive[i] = 1'b0;
            expected_results.push_back(r);
        end
    endtask

    function automatic bit idle_roll();
        return !quiet_phase && ($urandom_range(99) < 20);
    endfunction

    // request driver
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                predict_pool(pending_requests.pop_front());
            end
            if ((!s_tvalid || s_tready) ) begin
                if (pending_requests.size() != 0 && !idle_roll()) begin
                    s_tvalid <= 1'b1;
                    s_tuser <= pending_requests[0].action;
                    s_tdata <= pending_requests[0].payload;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        pool_result_t got, want;
        cycles <= cycles + 1;
        if (rst_n) begin
            m_tready <= !idle_roll();
            if (m_tvalid && m_tready) begin
                got.slot = m_tdata[5:0];
                got.px = m_tdata[6 +: 32];
                got.py = m_tdata[38 +: 32];
                got.pz = m_tdata[70 +: 32];
                got.ok = m_tuser[0];
                got.removed = m_tuser[1];
                got.last = m_tlast;
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", got);
                end
                else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
        end
        if (cycles > CYCLE_CAP) begin
            $display("tb_particle_pool_integrator_unit: errors");
            $finish;
        end
    end

    function automatic pool_request_t make_spawn(logic [DW-1:0] x, logic [DW-1:0] y,
                                                 logic [DW-1:0] z, logic [DW-1:0] fx,
                                                 logic [DW-1:0] fy, logic [DW-1:0] fz,
                                                 logic [MASS_W-1:0] m);
        pool_request_t rq;
        rq.action = ACT_SPAWN;
        rq.payload = {1'b0, m, fz, fy, fx, z, y, x};
        return rq;
    endfunction

    function automatic pool_request_t make_tick();
        pool_request_t rq;
        rq.action = ACT_TICK;
        rq.payload = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return rq;
    endfunction

    function automatic pool_request_t random_spawn();
        logic [DW-1:0] h;
        h = 32'h0001_0000 * $urandom_range(1, 200);
        if ($urandom_range(9) == 0)
            return make_spawn($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                              MASS_W'($urandom));
        return make_spawn($urandom, h, $urandom, $urandom_range(0, 4095) - 2048,
                          $urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048,
                          $urandom_range(1, 2) == 1 ? 31'h7fffffff :
                                                      MASS_W'(32'h10000 * $urandom_range(1, 8)));
    endfunction

    // waits until every expected result is in, then a settle gap
    task automatic drain();
        while (pending_requests.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic signed [DW-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_GRAVITY_Y: g_y = v;
            REG_WIND_X:    w_x = v;
            REG_WIND_Y:    w_y = v;
            REG_WIND_Z:    w_z = v;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic random_phase(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(2) == 0) pending_requests.push_back(make_tick());
            else pending_requests.push_back(random_spawn());
        end
    endtask

    initial begin
        g_y = GRAVITY_Y_RST;
        w_x = WIND_X_RST;
        w_y = '0;
        w_z = '0;
        cursor = 0;
        foreach (alive[i]) alive[i] = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty tick, extremes, zero mass, fall below ground
        pending_requests.push_back(make_tick());
        pending_requests.push_back(make_spawn(32'h7fffffff, 32'h7fffffff, 32'h80000000,
                                              32'h7fffffff, 32'h7fffffff, 32'h80000000, 31'd1));
        pending_requests.push_back(make_spawn(32'h80000000, 32'h0, 32'h7fffffff,
                                              32'h80000000, 32'h80000000, 32'h7fffffff,
                                              31'h7fffffff));
        pending_requests.push_back(make_spawn(32'h0, 32'h10, 32'h0, 32'h0, 32'hffff0000,
                                              32'h0, 31'd0));
        pending_requests.push_back(make_spawn(32'hffffffff, 32'hffffffff, 32'hffffffff,
                                              32'hffffffff, 32'hffffffff, 32'hffffffff,
                                              31'h7fffffff));
        repeat (3) pending_requests.push_back(make_tick());
        drain();

        // fill the pool, then one spawn too many
        quiet_phase = 1'b1;
        for (int k = 0; k < NSLOT + 1; k++)
            pending_requests.push_back(make_spawn($urandom, 32'h7000_0000, $urandom, 0, 0, 0,
                                                  31'h7fffffff));
        pending_requests.push_back(make_tick());
        drain();
        quiet_phase = 1'b0;

        // extremes of the registers, plus an ignored index
        write_reg(REG_GRAVITY_Y, 32'h80000000);
        write_reg(REG_WIND_X, 32'h7fffffff);
        write_reg(REG_WIND_Y, 32'h80000000);
        write_reg(REG_WIND_Z, 32'h7fffffff);
        write_reg(REG_UNUSED_IDX, 32'h12345678);
        pending_requests.push_back(make_tick());
        random_phase(10);
        drain();

        write_reg(REG_GRAVITY_Y, -32'sd655);
        write_reg(REG_WIND_X, $urandom);
        write_reg(REG_WIND_Y, 32'h0);
        write_reg(REG_WIND_Z, 32'h7fffffff);
        random_phase(10);
        drain();

        write_reg(REG_GRAVITY_Y, 32'h7fffffff);
        write_reg(REG_WIND_X, 32'h0);
        write_reg(REG_WIND_Y, $urandom);
        write_reg(REG_WIND_Z, 32'h80000000);
        random_phase(10);
        drain();

        if (mismatches == 0)
            $display("tb_particle_pool_integrator_unit: clean");
        else
            $display("tb_particle_pool_integrator_unit: errors");
        $finish;
    end
endmodule
